[rtl/smf_pkg.sv]
// Shared types and constants for the symmetric match filter.
// No dependencies; imported by the filter unit and its checker.
package smf_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int INDEX_BITS  = 16;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_TEST  = 2'd2;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] query_index;
        logic [15:0] train_index;
        logic        has_two;
    } req_t;

    typedef struct packed {
        logic        kept;
        logic [15:0] out_query_index;
        logic [15:0] out_train_index;
    } rsp_t;

    // one stored reverse match
    typedef struct packed {
        index_t query;
        index_t train;
    } pair_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

endpackage

[rtl/symmetric_match_filter_unit.sv]
// Symmetric match filter: reverse match table in one synchronous RAM plus scan control.
// Depends on smf_pkg.
//
// Clear and load requests are taken in the idle state and give no response. A test request
// scans the stored reverse matches one entry per cycle through the single read port
// of the table RAM, stopping at the first swapped-index hit. Each entry read is registered
// before it is compared; on a hit or after the last entry the block enters the done state,
// which writes the response into the output register once that register is free and then
// returns to idle. A test with has_two low, or against an empty table, skips the scan and
// goes straight to the done state. The block takes one request at a time; a finished
// response waits in the output register while the next request is accepted, and a test
// that finishes while that response is still stalled waits for it.
module symmetric_match_filter_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  smf_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output smf_pkg::rsp_t rsp
);
    import smf_pkg::*;

    pair_t  table_mem [TABLE_DEPTH];

    state_t state_reg, state_next;
    count_t count_reg, count_next;
    count_t ptr_reg, ptr_next;
    logic   rd_valid_reg, rd_valid_next;
    logic   rd_last_reg, rd_last_next;
    pair_t  rd_data_reg;
    index_t q_reg, q_next;
    index_t t_reg, t_next;
    logic   kept_reg, kept_next;
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   rsp_reg, rsp_next;

    logic   accept;
    logic   wr_en;
    logic   issue;
    logic   hit;
    logic   out_free;

    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign issue    = (state_reg == ST_SEARCH) && (ptr_reg < count_reg);
    assign hit      = rd_valid_reg && (rd_data_reg.train == q_reg)
                      && (rd_data_reg.query == t_reg);
    assign wr_en    = accept && (req.command == CMD_LOAD) && req.has_two
                      && (count_reg < count_t'(TABLE_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.command == CMD_TEST))
                begin
                    if (req.has_two && (count_reg != '0))
                        state_next = ST_SEARCH;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                if (hit || (rd_valid_reg && rd_last_reg))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_stall      = (state_reg != ST_IDLE);
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        rd_valid_next  = 1'b0;
        rd_last_next   = 1'b0;
        q_next         = q_reg;
        t_next         = t_reg;
        kept_next      = kept_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.command)
                        CMD_CLEAR: count_next = '0;
                        CMD_LOAD:
                        begin
                            if (wr_en)
                                count_next = count_reg + 1'b1;
                        end
                        CMD_TEST:
                        begin
                            q_next    = index_t'(req.query_index);
                            t_next    = index_t'(req.train_index);
                            kept_next = 1'b0;
                            ptr_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (issue)
                begin
                    ptr_next      = ptr_reg + 1'b1;
                    rd_valid_next = 1'b1;
                    rd_last_next  = (count_t'(ptr_reg + 1'b1) == count_reg);
                end
                if (hit)
                    kept_next = 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.kept            = kept_reg;
                    rsp_next.out_query_index = 16'(q_reg);
                    rsp_next.out_train_index = 16'(t_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        t_reg    <= t_next;
        kept_reg <= kept_next;
        rsp_reg  <= rsp_next;
    end

    // table RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[count_reg[ADDR_BITS-1:0]] <= '{query: index_t'(req.query_index),
                                                     train: index_t'(req.train_index)};
        end
        if (issue)
            rd_data_reg <= table_mem[ptr_reg[ADDR_BITS-1:0]];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/smf_checker.sv]
// Port-level checks for the symmetric match filter unit, bound to the top level.
// Depends on smf_pkg and symmetric_match_filter_unit.
module smf_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input smf_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input smf_pkg::rsp_t rsp
);
    import smf_pkg::*;

    // a waiting response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // an accepted test request always occupies the block
    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.command == CMD_TEST) |=> req_stall)
        else $error("test request did not occupy the block");

    // requests other than test (clear, load, unused) leave the block free in the next cycle
    a_other_quick: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.command != CMD_TEST) |=> !req_stall)
        else $error("non-test request stalled the block");

    // a new response only follows a busy cycle
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared without a test in progress");

endmodule

bind symmetric_match_filter_unit smf_checker u_smf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[tb/symmetric_match_filter_unit_test.sv]
// Self-checking bench for the symmetric match filter: a scoreboard class predicts each
// test verdict from its own copy of the reverse table. Depends on smf_pkg and the unit.
`timescale 1ns / 1ps

module symmetric_match_filter_unit_test;
    import smf_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         RANDOM_ITEMS = 580;

    class match_verdict_board;
        index_t      rev_query [TABLE_DEPTH];
        index_t      rev_train [TABLE_DEPTH];
        int unsigned pair_count;
        rsp_t        pending_verdicts [$];
        int unsigned errors;
        int unsigned kept_total;
        int unsigned dropped_total;
        int unsigned loads_total;
        int unsigned clears_total;
        int unsigned peak_pairs;

        function new();
            pair_count    = 0;
            errors        = 0;
            kept_total    = 0;
            dropped_total = 0;
            loads_total   = 0;
            clears_total  = 0;
            peak_pairs    = 0;
        endfunction

        // apply one accepted request to the table copy; a test queues its verdict
        function void note_request(req_t r);
            index_t q;
            index_t t;
            bit     hit;
            int     i;
            rsp_t   v;
            q   = index_t'(r.query_index);
            t   = index_t'(r.train_index);
            hit = 1'b0;
            case (r.command)
                CMD_CLEAR:
                begin
                    pair_count = 0;
                    clears_total++;
                end
                CMD_LOAD:
                begin
                    if (r.has_two && pair_count < TABLE_DEPTH)
                    begin
                        rev_query[pair_count] = q;
                        rev_train[pair_count] = t;
                        pair_count++;
                        loads_total++;
                        if (pair_count > peak_pairs)
                            peak_pairs = pair_count;
                    end
                end
                CMD_TEST:
                begin
                    if (r.has_two)
                        for (i = 0; i < pair_count && !hit; i++)
                            if (rev_train[i] == q && rev_query[i] == t)
                                hit = 1'b1;
                    v.kept            = hit;
                    v.out_query_index = r.query_index;
                    v.out_train_index = r.train_index;
                    pending_verdicts.insert(pending_verdicts.size(), v);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_verdict(rsp_t got);
            rsp_t want;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response %h", got));
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.kept !== want.kept)
                report_mismatch($sformatf("kept %b, want %b (q %h t %h)", got.kept,
                                          want.kept, want.out_query_index,
                                          want.out_train_index));
            if (got.out_query_index !== want.out_query_index)
                report_mismatch($sformatf("query %h, want %h", got.out_query_index,
                                          want.out_query_index));
            if (got.out_train_index !== want.out_train_index)
                report_mismatch($sformatf("train %h, want %h", got.out_train_index,
                                          want.out_train_index));
            if (want.kept)
                kept_total++;
            else
                dropped_total++;
        endtask

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   req_valid;
    logic   req_stall;
    req_t   req;
    logic   rsp_valid;
    logic   rsp_stall;
    rsp_t   rsp;

    match_verdict_board board;
    pair_t              loaded [$];
    int unsigned        counted_items;
    int unsigned        cycle_count = 0;
    bit                 sender_quiet;
    bit                 receiver_quiet;

    symmetric_match_filter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                     board.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // hold request on the bus until taken; idle gap drawn per request
    task automatic send_request(req_t r);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_quiet = !sender_quiet;
        gap = sender_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
    endtask

    // builds the request and mirrors the table so tests can aim at stored pairs
    task automatic send(logic [1:0] cmd, logic [15:0] q, logic [15:0] t, logic two);
        req_t  r;
        pair_t p;
        r.command     = cmd;
        r.query_index = q;
        r.train_index = t;
        r.has_two     = two;
        send_request(r);
        if (cmd == CMD_CLEAR)
            loaded.delete();
        else if (cmd == CMD_LOAD && two && loaded.size() < TABLE_DEPTH)
        begin
            p.query = q;
            p.train = t;
            loaded.insert(loaded.size(), p);
        end
        if (cmd != CMD_UNUSED)
            counted_items++;
    endtask

    task automatic drain();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_test();
        pair_t p;
        int    kind;
        logic  two;
        kind = $urandom_range(0, 99);
        two  = ($urandom_range(0, 9) != 0);
        if (loaded.size() != 0)
            p = loaded[$urandom_range(0, loaded.size() - 1)];
        else
        begin
            p.query = 16'($urandom);
            p.train = 16'($urandom);
        end
        if (kind < 55)
            send(CMD_TEST, p.train, p.query, two);
        else if (kind < 70)
        begin
            // one bit off from a stored pair
            if ($urandom_range(0, 1))
                send(CMD_TEST, p.train ^ (16'h1 << $urandom_range(0, 15)), p.query, two);
            else
                send(CMD_TEST, p.train, p.query ^ (16'h1 << $urandom_range(0, 15)), two);
        end
        else if (kind < 80)
            send(CMD_TEST, p.query, p.train, two);
        else
            send(CMD_TEST, 16'($urandom), 16'($urandom), two);
    endtask

    initial
    begin
        logic [15:0] fill_q;
        int          n_loads;
        int          n_tests;
        int          i;

        board          = new();
        rst_n          = 1'b0;
        req_valid      <= 1'b0;
        req            <= '0;
        counted_items  = 0;
        sender_quiet   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, ignored loads and commands, extremes, clear
        send(CMD_TEST,   16'h0000, 16'h0000, 1'b1);
        send(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
        send(CMD_LOAD,   16'hFFFF, 16'h0000, 1'b0);
        send(CMD_TEST,   16'h0000, 16'hFFFF, 1'b1);
        send(CMD_LOAD,   16'hFFFF, 16'h0000, 1'b1);
        send(CMD_LOAD,   16'h0000, 16'h0000, 1'b1);
        send(CMD_LOAD,   16'h1234, 16'hABCD, 1'b1);
        send(CMD_UNUSED, 16'hCDAB, 16'h3412, 1'b0);
        send(CMD_TEST,   16'h0000, 16'hFFFF, 1'b1);
        send(CMD_TEST,   16'hFFFF, 16'h0000, 1'b1);
        send(CMD_TEST,   16'h0000, 16'h0000, 1'b1);
        send(CMD_TEST,   16'hABCD, 16'h1234, 1'b1);
        send(CMD_TEST,   16'hABCD, 16'h1234, 1'b0);
        send(CMD_TEST,   16'hABCD, 16'h1235, 1'b1);
        send(CMD_TEST,   16'hFFFF, 16'hFFFF, 1'b1);
        send(CMD_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1);
        send(CMD_TEST,   16'hABCD, 16'h1234, 1'b1);
        send(CMD_TEST,   16'h0000, 16'h0000, 1'b0);
        send(CMD_CLEAR,  16'h0000, 16'h0000, 1'b0);
        req_valid <= 1'b0;
        drain();

        // full table: overflow loads must not land, scans run the whole depth
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            fill_q = 16'(i * 37 + 5);
            send(CMD_LOAD, fill_q, 16'($urandom), 1'b1);
        end
        send(CMD_LOAD, 16'h7FFE, 16'h8001, 1'b1);
        send(CMD_LOAD, 16'h7FFF, 16'h8000, 1'b1);
        send(CMD_TEST, loaded[TABLE_DEPTH - 1].train, loaded[TABLE_DEPTH - 1].query, 1'b1);
        send(CMD_TEST, loaded[0].train, loaded[0].query, 1'b1);
        send(CMD_TEST, 16'h8000, 16'h7FFF, 1'b1);
        send(CMD_TEST, loaded[500].train, loaded[500].query ^ 16'h8000, 1'b1);
        send(CMD_TEST, loaded[700].train, loaded[700].query, 1'b0);
        send(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'b1);

        // random: mostly clear, load a batch, test against it
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
                send(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                  : $urandom_range(0, 12);
            for (i = 0; i < n_loads; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send(CMD_UNUSED, 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
                send(CMD_LOAD, 16'($urandom), 16'($urandom), $urandom_range(0, 9) != 0);
            end
            n_tests = $urandom_range(1, 10);
            for (i = 0; i < n_tests; i++)
                random_test();
            if ($urandom_range(0, 7) == 0)
            begin
                req_valid <= 1'b0;
                drain();
            end
        end
        req_valid <= 1'b0;

        drain();
        repeat (64) @(posedge clk);
        $display("Checked %0d verdicts (%0d kept, %0d dropped)",
                 board.kept_total + board.dropped_total, board.kept_total,
                 board.dropped_total);
        $display("over %0d stored loads and %0d clears; largest table %0d pairs, %0d cycles",
                 board.loads_total, board.clears_total, board.peak_pairs, cycle_count);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // response side: stall for a drawn number of cycles, then take one verdict
    initial
    begin
        int gap;
        rsp_stall      <= 1'b0;
        receiver_quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                receiver_quiet = !receiver_quiet;
            gap = receiver_quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            board.check_verdict(rsp);
        end
    end

endmodule

[files.f]
rtl/smf_pkg.sv
rtl/symmetric_match_filter_unit.sv
rtl/smf_checker.sv
tb/symmetric_match_filter_unit_test.sv
